>>> design/hsv_pixel_color_classifier_core_macros.svh
// Assertion macros for the HSV pixel colour classifier.
`ifndef HSV_PIXEL_COLOR_CLASSIFIER_CORE_MACROS_SVH
`define HSV_PIXEL_COLOR_CLASSIFIER_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define HSV_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsv assertion failed");
// Next-cycle implication.
`define HSV_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hsv assertion failed");
`else
`define HSV_ASSERT_IMP(name, clk, rst, ante, cons)
`define HSV_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

>>> design/hsv_pkg.sv
// Shared types, constants and functions of the HSV pixel colour classifier.
package hsv_pkg;

   // Divider geometry: 13 quotient bits, 20-bit dividend, 8-bit divisor
   localparam int QUO_W     = 13;
   localparam int DIVD_W    = 20;
   localparam int DIV_STEPS = QUO_W;

   localparam logic [11:0] HUE_FULL     = 12'd2880;
   localparam logic [12:0] SAT_SCALE    = 13'd4096;
   localparam logic [11:0] HUE_OFF_RED  = 12'd0;
   localparam logic [11:0] HUE_OFF_GRN  = 12'd960;
   localparam logic [11:0] HUE_OFF_BLU  = 12'd1920;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAT_LIMIT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DARK_LIMIT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_YEL_LOW    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRN_LOW    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRN_HIGH   = 3'd4;
   localparam int CSR_DATA_W = 13;

   typedef enum logic [1:0] {
      SECTOR_RED   = 2'd0,
      SECTOR_GREEN = 2'd1,
      SECTOR_BLUE  = 2'd2
   } sector_type;

   typedef enum logic [1:0] {
      CLASS_BLACK  = 2'd0,
      CLASS_GRAY   = 2'd1,
      CLASS_YELLOW = 2'd2,
      CLASS_GREEN  = 2'd3
   } color_class_type;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  color_class;
      logic [7:0]  red_out;
      logic [7:0]  green_out;
      logic [7:0]  blue_out;
      logic [11:0] hue;
      logic [12:0] saturation;
      logic [7:0]  brightness;
   } rsp_type;

   typedef struct packed {
      logic [12:0] sat_limit;
      logic [8:0]  dark_limit;
      logic [11:0] yellow_low;
      logic [11:0] green_low;
      logic [11:0] green_high;
   } cfg_type;

   // One restoring-divider lane: partial remainder, dividend/quotient shifter
   typedef struct packed {
      logic [7:0]       rem;
      logic [QUO_W-1:0] bits;
      logic [7:0]       divisor;
   } div_lane_type;

   typedef struct packed {
      div_lane_type hue;
      div_lane_type sat;
      logic         hue_neg;
      sector_type   sector;
      logic [7:0]   brightness;
   } div_type;

   function automatic logic [23:0] class_palette(color_class_type cls);
      logic [23:0] rgb;
      case (cls)
         CLASS_BLACK:  rgb = {8'd0,   8'd0,   8'd0};
         CLASS_GRAY:   rgb = {8'd120, 8'd120, 8'd120};
         CLASS_YELLOW: rgb = {8'd180, 8'd160, 8'd60};
         CLASS_GREEN:  rgb = {8'd80,  8'd140, 8'd80};
         default:      rgb = {8'd0,   8'd0,   8'd0};
      endcase
      return rgb;
   endfunction

   function automatic logic [11:0] sector_offset(sector_type sec);
      logic [11:0] off;
      case (sec)
         SECTOR_RED:   off = HUE_OFF_RED;
         SECTOR_GREEN: off = HUE_OFF_GRN;
         SECTOR_BLUE:  off = HUE_OFF_BLU;
         default:      off = HUE_OFF_RED;
      endcase
      return off;
   endfunction

endpackage

>>> design/hsv_pixel_color_classifier_core.sv
// Top level of the HSV pixel colour classifier: CSRs and pipeline assembly.
//
//   channel   direction   handshake            payload
//   req_      in          req_valid/req_stall  hsv_pkg::req_type (red, green, blue)
//   rsp_      out         rsp_valid/rsp_stall  hsv_pkg::rsp_type (class, palette, HSV)
//   csr_      in          csr_we               csr_index, csr_wdata
//
// One pixel per clock while rsp_stall is low; 2 front-end stages, 13 divider stages
// (one quotient bit per stage for both the hue and saturation dividers), 2 back-end stages.
// Synchronous reset clears every stage's valid bit and loads the threshold defaults.
// Each stage holds while its successor is full; empty stages keep filling, so
// bubbles close up and nothing is dropped or repeated under rsp_stall.
module hsv_pixel_color_classifier_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  hsv_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output hsv_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [hsv_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hsv_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import hsv_pkg::*;

   cfg_type cfg_ff;
   logic    front_ready;
   logic    fin_ready;
   logic    div_valid [0:DIV_STEPS];
   div_type div_data  [0:DIV_STEPS];
   logic    div_ready [0:DIV_STEPS];

   // Threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sat_limit  <= 13'd615;
         cfg_ff.dark_limit <= 9'd51;
         cfg_ff.yellow_low <= 12'd240;
         cfg_ff.green_low  <= 12'd720;
         cfg_ff.green_high <= 12'd1200;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SAT_LIMIT:  cfg_ff.sat_limit  <= csr_wdata;
            CSR_DARK_LIMIT: cfg_ff.dark_limit <= csr_wdata[8:0];
            CSR_YEL_LOW:    cfg_ff.yellow_low <= csr_wdata[11:0];
            CSR_GRN_LOW:    cfg_ff.green_low  <= csr_wdata[11:0];
            CSR_GRN_HIGH:   cfg_ff.green_high <= csr_wdata[11:0];
            default:        ;
         endcase
      end
   end

   hsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .in_ready  (front_ready),
      .out_valid (div_valid[0]),
      .out_data  (div_data[0]),
      .out_ready (div_ready[0])
   );

   // Divider chain
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      hsv_div_stage u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[i]),
         .in_data   (div_data[i]),
         .in_ready  (div_ready[i]),
         .out_valid (div_valid[i+1]),
         .out_data  (div_data[i+1]),
         .out_ready (div_ready[i+1])
      );
   end

   assign div_ready[DIV_STEPS] = fin_ready;

   hsv_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (div_valid[DIV_STEPS]),
      .in_data   (div_data[DIV_STEPS]),
      .in_ready  (fin_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_ready (!rsp_stall)
   );

   assign req_stall = !front_ready;

endmodule

>>> design/hsv_front.sv
// Front end: max/min search, hue sector, then delta and divider set-up.
module hsv_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  hsv_pkg::req_type in_data,
   output logic             in_ready,
   output logic             out_valid,
   output hsv_pkg::div_type out_data,
   input  logic             out_ready
);
   import hsv_pkg::*;

   typedef struct packed {
      logic [7:0] mx;
      logic [7:0] mn;
      sector_type sector;
      logic [7:0] num_a;
      logic [7:0] num_b;
   } minmax_type;

   logic       s1_valid_ff;
   minmax_type s1_data_ff;
   minmax_type s1_data_in;
   logic       s1_ready;
   logic       s2_valid_ff;
   div_type    s2_data_ff;
   div_type    s2_data_in;
   logic       s2_ready;

   // Stage 1: max, min and which channel leads
   always_comb begin
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] mx;
      logic [7:0] mn;
      r  = in_data.red_in;
      g  = in_data.green_in;
      b  = in_data.blue_in;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      s1_data_in.mx = mx;
      s1_data_in.mn = mn;
      if (mx == r) begin
         s1_data_in.sector = SECTOR_RED;
         s1_data_in.num_a  = g;
         s1_data_in.num_b  = b;
      end else if (mx == g) begin
         s1_data_in.sector = SECTOR_GREEN;
         s1_data_in.num_a  = b;
         s1_data_in.num_b  = r;
      end else begin
         s1_data_in.sector = SECTOR_BLUE;
         s1_data_in.num_a  = r;
         s1_data_in.num_b  = g;
      end
   end

   // Stage 2: delta, numerator magnitude, dividends 480*|num| and 4096*delta
   always_comb begin
      logic [7:0]        delta;
      logic [7:0]        mag;
      logic              neg;
      logic [DIVD_W-1:0] dvd_hue;
      logic [DIVD_W-1:0] dvd_sat;
      delta   = s1_data_ff.mx - s1_data_ff.mn;
      neg     = s1_data_ff.num_a < s1_data_ff.num_b;
      mag     = neg ? (s1_data_ff.num_b - s1_data_ff.num_a)
                    : (s1_data_ff.num_a - s1_data_ff.num_b);
      dvd_hue = ({{(DIVD_W-8){1'b0}}, mag} << 9) - ({{(DIVD_W-8){1'b0}}, mag} << 5);
      dvd_sat = {delta, {(DIVD_W-8){1'b0}}};
      s2_data_in.hue.rem     = {1'b0, dvd_hue[DIVD_W-1:QUO_W]};
      s2_data_in.hue.bits    = dvd_hue[QUO_W-1:0];
      s2_data_in.hue.divisor = delta;
      s2_data_in.sat.rem     = {1'b0, dvd_sat[DIVD_W-1:QUO_W]};
      s2_data_in.sat.bits    = dvd_sat[QUO_W-1:0];
      s2_data_in.sat.divisor = s1_data_ff.mx;
      s2_data_in.hue_neg     = neg;
      s2_data_in.sector      = s1_data_ff.sector;
      s2_data_in.brightness  = s1_data_ff.mx;
   end

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
      if (s1_ready && in_valid)    s1_data_ff <= s1_data_in;
      if (s2_ready && s1_valid_ff) s2_data_ff <= s2_data_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

>>> design/hsv_div_stage.sv
// One restoring-division step for the hue and saturation lanes.
`include "hsv_pixel_color_classifier_core_macros.svh"
module hsv_div_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  hsv_pkg::div_type in_data,
   output logic             in_ready,
   output logic             out_valid,
   output hsv_pkg::div_type out_data,
   input  logic             out_ready
);
   import hsv_pkg::*;

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;

   // Shift in the next dividend bit, subtract when it fits, shift in the quotient bit
   function automatic div_lane_type lane_step(div_lane_type l);
      div_lane_type o;
      logic [8:0]   trial;
      logic [8:0]   dvs;
      trial = {l.rem, l.bits[QUO_W-1]};
      dvs   = {1'b0, l.divisor};
      o     = l;
      if (trial >= dvs) begin
         o.rem  = 8'(trial - dvs);
         o.bits = {l.bits[QUO_W-2:0], 1'b1};
      end else begin
         o.rem  = trial[7:0];
         o.bits = {l.bits[QUO_W-2:0], 1'b0};
      end
      return o;
   endfunction

   always_comb begin
      data_in     = in_data;
      data_in.hue = lane_step(in_data.hue);
      data_in.sat = lane_step(in_data.sat);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Partial remainders stay below their divisors
   `HSV_ASSERT_IMP(a_sat_rem_bound, clock, reset, valid_ff && (data_ff.sat.divisor != 8'd0), data_ff.sat.rem < data_ff.sat.divisor)
   `HSV_ASSERT_IMP(a_hue_rem_bound, clock, reset, valid_ff && (data_ff.hue.divisor != 8'd0), data_ff.hue.rem < data_ff.hue.divisor)
   // A zero maximum means a zero delta
   `HSV_ASSERT_IMP(a_black_no_delta, clock, reset, valid_ff && (data_ff.sat.divisor == 8'd0), data_ff.hue.divisor == 8'd0)

endmodule

>>> design/hsv_finish.sv
// Back end: hue rounding, sector offset and wrap, then class and palette.
`include "hsv_pixel_color_classifier_core_macros.svh"
module hsv_finish (
   input  logic             clock,
   input  logic             reset,
   input  hsv_pkg::cfg_type cfg,
   input  logic             in_valid,
   input  hsv_pkg::div_type in_data,
   output logic             in_ready,
   output logic             out_valid,
   output hsv_pkg::rsp_type out_data,
   input  logic             out_ready
);
   import hsv_pkg::*;

   typedef struct packed {
      logic [11:0] hue;
      logic [12:0] saturation;
      logic [7:0]  brightness;
   } hsv_val_type;

   logic        a_valid_ff;
   hsv_val_type a_data_ff;
   hsv_val_type a_data_in;
   logic        a_ready;
   logic        b_valid_ff;
   rsp_type     b_data_ff;
   rsp_type     b_data_in;
   logic        b_ready;

   // Stage A: floor of the signed quotient, sector offset, wrap into 0..2879
   always_comb begin
      logic              round_up;
      logic [9:0]        mag;
      logic signed [12:0] base;
      logic signed [12:0] h;
      round_up = in_data.hue_neg && (in_data.hue.rem != 8'd0);
      mag      = {1'b0, in_data.hue.bits[8:0]} + {9'd0, round_up};
      base     = $signed({1'b0, sector_offset(in_data.sector)});
      if (in_data.hue_neg) h = base - $signed({3'b000, mag});
      else                 h = base + $signed({3'b000, mag});
      if (h < 13'sd0) h = h + $signed({1'b0, HUE_FULL});
      if (in_data.hue.divisor == 8'd0) h = 13'sd0;
      a_data_in.hue        = h[11:0];
      a_data_in.saturation = (in_data.sat.divisor == 8'd0) ? 13'd0 : in_data.sat.bits;
      a_data_in.brightness = in_data.brightness;
   end

   // Stage B: threshold tests and palette lookup
   always_comb begin
      color_class_type cls;
      logic [23:0]     rgb;
      if (a_data_ff.saturation < cfg.sat_limit) begin
         cls = ({1'b0, a_data_ff.brightness} < cfg.dark_limit) ? CLASS_BLACK : CLASS_GRAY;
      end else if ((a_data_ff.hue >= cfg.yellow_low) && (a_data_ff.hue < cfg.green_low)) begin
         cls = CLASS_YELLOW;
      end else if ((a_data_ff.hue >= cfg.green_low) && (a_data_ff.hue < cfg.green_high)) begin
         cls = CLASS_GREEN;
      end else begin
         cls = CLASS_BLACK;
      end
      rgb                   = class_palette(cls);
      b_data_in.color_class = cls;
      b_data_in.red_out     = rgb[23:16];
      b_data_in.green_out   = rgb[15:8];
      b_data_in.blue_out    = rgb[7:0];
      b_data_in.hue         = a_data_ff.hue;
      b_data_in.saturation  = a_data_ff.saturation;
      b_data_in.brightness  = a_data_ff.brightness;
   end

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
      end
      if (a_ready && in_valid)   a_data_ff <= a_data_in;
      if (b_ready && a_valid_ff) b_data_ff <= b_data_in;
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

   // Hue always wrapped into range, saturation never above full scale
   `HSV_ASSERT_IMP(a_hue_range, clock, reset, a_valid_ff, a_data_ff.hue < HUE_FULL)
   `HSV_ASSERT_IMP(a_sat_range, clock, reset, b_valid_ff, b_data_ff.saturation <= SAT_SCALE)
   // An all-zero pixel has no saturation and no hue
   `HSV_ASSERT_IMP(a_black_pixel, clock, reset, b_valid_ff && (b_data_ff.brightness == 8'd0), (b_data_ff.saturation == 13'd0) && (b_data_ff.hue == 12'd0))
   // A held stage A transaction is still there next cycle
   `HSV_ASSERT_NXT(a_stage_hold, clock, reset, a_valid_ff && !b_ready, a_valid_ff)

endmodule
